// File: sv/fbm_pkg.sv
// Shared types, constants and codes of the frame bitmap allocator.
`default_nettype none

package fbm_pkg;

    localparam int DEF_MAX_FRAMES = 4096;
    localparam int DEF_WORD_BITS  = 32;

    localparam int CMD_W    = 2;
    localparam int FRAME_W  = 12;
    localparam int LEN_W    = 13;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 13;

    localparam logic [LEN_W-1:0] FC_RESET = 13'd4096;

    typedef enum logic [CMD_W-1:0] {
        CMD_MARK  = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_FIND  = 2'd2,
        CMD_ALLOC = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    typedef struct packed {
        logic clear;
        logic load;
        logic start;
        logic modify;
        logic scan;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic clear_last;
        logic early_done;
        logic rmw;
        logic scan_done;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: sv/fbm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module fbm_ram
    import fbm_pkg::*;
#(
    parameter int WIDTH = DEF_WORD_BITS,
    parameter int DEPTH = DEF_MAX_FRAMES / DEF_WORD_BITS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: sv/fbm_ctrl.sv
// Controller state machine of the frame bitmap allocator.
`default_nettype none

module fbm_ctrl
    import fbm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_out_stall,
    input  wire t_dp_stat i_stat,
    output t_ctl_cmd      o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_START  = 6'b000100,
        S_MODIFY = 6'b001000,
        S_SCAN   = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                if (i_stat.early_done) begin
                    n_state = S_FINISH;
                end else if (i_stat.rmw) begin
                    n_state = S_MODIFY;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_MODIFY: begin
                o_cmd.modify = 1'b1;
                n_state      = S_FINISH;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: sv/fbm_dp.sv
// Datapath of the frame bitmap allocator: bitmap RAM, word scanner, counters, result.
`default_nettype none

module fbm_dp
    import fbm_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int WORD_BITS  = DEF_WORD_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_ctl_cmd            i_cmd,
    output t_dp_stat                 o_stat,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [LEN_W-1:0]    i_cfg_wr_data,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [FRAME_W-1:0]  i_frame_number,
    input  wire logic [LEN_W-1:0]    i_run_length,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [FRAME_W-1:0]  o_found_frame,
    output logic      [CNT_W-1:0]    o_used_total
);

    localparam int WORDS = MAX_FRAMES / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(WORD_BITS);
    localparam int FW    = $clog2(MAX_FRAMES + 1);
    localparam int LW    = (FW > LEN_W) ? FW : LEN_W;
    localparam int RUN_W = LEN_W + 1;

    localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);
    localparam logic [LW-1:0] MAX_L     = LW'(MAX_FRAMES);
    localparam logic [LW-1:0] WB_L      = LW'(WORD_BITS);
    localparam logic [BW:0]   WB_S      = (BW + 1)'(WORD_BITS);

    logic [LEN_W-1:0]     r_fc;
    t_cmd                 r_command;
    logic [FRAME_W-1:0]   r_frame;
    logic [LEN_W-1:0]     r_len;
    logic [CNT_W-1:0]     r_used;
    logic [AW-1:0]        r_addr;
    logic [AW-1:0]        r_proc;
    logic                 r_dvalid;
    logic [LEN_W-1:0]     r_run;
    t_status              r_res_status;
    logic [FRAME_W-1:0]   r_res_found;
    logic                 r_wpend;
    logic                 r_inc;
    logic                 r_dec;
    logic [AW-1:0]        r_waddr;
    logic [WORD_BITS-1:0] r_wword;
    logic [STATUS_W-1:0]  r_o_status;
    logic [FRAME_W-1:0]   r_o_found;
    logic [CNT_W-1:0]     r_o_used;

    logic [LW-1:0]        fc_l;
    logic [LW-1:0]        live;
    logic [LW-1:0]        fr_l;
    logic [AW-1:0]        fr_word;
    logic [BW-1:0]        fr_bit;
    logic                 is_mf;
    logic                 range_err;
    logic                 len_err;
    logic [WORD_BITS-1:0] bit_oh;
    logic                 old_bit;
    logic [LEN_W-1:0]     len_eff;
    logic [LW-1:0]        base;
    logic [LW-1:0]        diff;
    logic [BW:0]          lim;
    logic                 last;
    logic [WORD_BITS-1:0] used_m;
    logic [RUN_W-1:0]     run_arr [WORD_BITS];
    logic [WORD_BITS-1:0] hit_v;
    logic                 hit;
    logic [BW-1:0]        hit_p;
    logic [WORD_BITS-1:0] hit_oh;
    logic [LW-1:0]        found_l;
    logic [LEN_W-1:0]     run_top;
    logic [CNT_W-1:0]     n_used;

    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic [AW-1:0]        ram_rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    assign fc_l      = LW'(r_fc);
    assign live      = (fc_l < MAX_L) ? fc_l : MAX_L;
    assign fr_l      = LW'(r_frame);
    assign fr_word   = fr_l[BW +: AW];
    assign fr_bit    = fr_l[BW-1:0];
    assign is_mf     = (r_command == CMD_MARK) || (r_command == CMD_FREE);
    assign range_err = is_mf && (fr_l >= live);
    assign len_err   = (r_command == CMD_FIND) && (r_len == '0);
    assign bit_oh    = WORD_BITS'(1) << fr_bit;
    assign old_bit   = rd_data[fr_bit];
    assign len_eff   = (r_command == CMD_ALLOC) ? LEN_W'(1) : r_len;
    assign base      = LW'(r_proc) << BW;
    assign last      = (base + WB_L) >= live;

    always_comb begin
        diff = live - base;
        if (base >= live) begin
            lim = '0;
        end else if (diff >= WB_L) begin
            lim = WB_S;
        end else begin
            lim = diff[BW:0];
        end
    end

    // run length of free frames ending at each bit, frames past the live count read as used
    always_comb begin
        logic          has;
        logic [BW-1:0] ls;
        for (int p = 0; p < WORD_BITS; p++) begin
            used_m[p] = rd_data[p] | ((BW + 1)'(p) >= lim);
        end
        for (int p = 0; p < WORD_BITS; p++) begin
            has = 1'b0;
            ls  = '0;
            for (int q = 0; q <= p; q++) begin
                if (used_m[q]) begin
                    has = 1'b1;
                    ls  = BW'(q);
                end
            end
            if (has) begin
                run_arr[p] = RUN_W'(BW'(p) - ls);
            end else begin
                run_arr[p] = RUN_W'(r_run) + RUN_W'(p) + RUN_W'(1);
            end
            hit_v[p] = !used_m[p] && (run_arr[p] >= RUN_W'(len_eff));
        end
    end

    always_comb begin
        hit_p = '0;
        for (int p = WORD_BITS - 1; p >= 0; p--) begin
            if (hit_v[p]) begin
                hit_p = BW'(p);
            end
        end
    end

    assign hit     = |hit_v;
    assign hit_oh  = WORD_BITS'(1) << hit_p;
    assign found_l = base + LW'(hit_p) + LW'(1) - LW'(len_eff);
    assign run_top = LEN_W'(run_arr[WORD_BITS-1]);
    assign n_used  = r_used + CNT_W'(r_inc) - CNT_W'(r_dec);

    assign o_stat.clear_last = (r_addr == LAST_ADDR);
    assign o_stat.early_done = range_err || len_err;
    assign o_stat.rmw        = is_mf;
    assign o_stat.scan_done  = r_dvalid && (hit || last);

    assign ram_rd_addr = i_cmd.start ? fr_word : r_addr;
    assign ram_wr_en   = i_cmd.clear || (i_cmd.commit && r_wpend);
    assign ram_wr_addr = i_cmd.clear ? r_addr : r_waddr;
    assign ram_wr_data = i_cmd.clear ? '0 : r_wword;

    fbm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= t_cmd'(i_command);
            r_frame   <= i_frame_number;
            r_len     <= i_run_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc     <= FC_RESET;
            r_used   <= '0;
            r_addr   <= '0;
            r_dvalid <= 1'b0;
            r_wpend  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_fc <= i_cfg_wr_data;
            end
            if (i_cmd.clear) begin
                r_addr <= o_stat.clear_last ? '0 : r_addr + AW'(1);
            end
            if (i_cmd.start) begin
                r_addr       <= '0;
                r_dvalid     <= 1'b0;
                r_run        <= '0;
                r_wpend      <= 1'b0;
                r_inc        <= 1'b0;
                r_dec        <= 1'b0;
                r_res_found  <= '0;
                r_res_status <= (range_err || len_err) ? ST_BAD : ST_OK;
                r_waddr      <= fr_word;
            end
            if (i_cmd.modify) begin
                if ((r_command == CMD_MARK) && !old_bit) begin
                    r_wword <= rd_data | bit_oh;
                    r_wpend <= 1'b1;
                    r_inc   <= 1'b1;
                end else if ((r_command == CMD_FREE) && old_bit) begin
                    r_wword <= rd_data & ~bit_oh;
                    r_wpend <= 1'b1;
                    r_dec   <= 1'b1;
                end
            end
            if (i_cmd.scan) begin
                r_addr   <= (r_addr == LAST_ADDR) ? r_addr : r_addr + AW'(1);
                r_proc   <= r_addr;
                r_dvalid <= 1'b1;
                if (r_dvalid) begin
                    r_run <= run_top;
                    if (hit) begin
                        r_res_found <= FRAME_W'(found_l);
                        if (r_command == CMD_ALLOC) begin
                            r_wword <= rd_data | hit_oh;
                            r_waddr <= r_proc;
                            r_wpend <= 1'b1;
                            r_inc   <= 1'b1;
                        end
                    end else if (last) begin
                        r_res_status <= ST_NOFIT;
                    end
                end
            end
            if (i_cmd.commit) begin
                r_wpend <= 1'b0;
                r_used  <= n_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_status <= r_res_status;
            r_o_found  <= r_res_found;
            r_o_used   <= n_used;
        end
    end

    assign o_status      = r_o_status;
    assign o_found_frame = r_o_found;
    assign o_used_total  = r_o_used;

endmodule

`default_nettype wire

// File: sv/frame_bitmap_allocator.sv
// Top level of the frame bitmap allocator: controller, datapath and checks.
//
// Input channel: i_in_valid / o_in_stall carry one command word (i_command,
// i_frame_number, i_run_length). Output channel: o_out_valid / i_out_stall carry
// one result word (o_status, o_found_frame, o_used_total) per command.
// Configuration: i_cfg_wr_en / i_cfg_wr_data write frame_count.
// One command is in flight at a time; o_in_stall is low only while idle.
// Flow from accept to result: errors go from the start state straight to finish,
// mark and free pass through the modify state (read-modify-write through the
// bitmap RAM), and find and allocate scan bitmap words until the run is found or
// the live frames end; the single RAM read port limits the scan to one word per
// cycle, at most MAX_FRAMES / WORD_BITS words (128 by default).
// Reset: synchronous, active low. After reset the block zeroes the bitmap, all
// MAX_FRAMES / WORD_BITS words of it, one word per cycle, with o_in_stall high;
// configuration writes are taken during that time.
// A result waits in the output register while i_out_stall is high; the next
// command is already accepted and finishes up to its result, then holds.
`default_nettype none

module frame_bitmap_allocator
    import fbm_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int WORD_BITS  = DEF_WORD_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [LEN_W-1:0]    i_cfg_wr_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [FRAME_W-1:0]  i_frame_number,
    input  wire logic [LEN_W-1:0]    i_run_length,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [FRAME_W-1:0]  o_found_frame,
    output logic      [CNT_W-1:0]    o_used_total
);

    t_ctl_cmd w_cmd;
    t_dp_stat w_stat;

    fbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    fbm_dp #(
        .MAX_FRAMES (MAX_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_command      (i_command),
        .i_frame_number (i_frame_number),
        .i_run_length   (i_run_length),
        .o_status       (o_status),
        .o_found_frame  (o_found_frame),
        .o_used_total   (o_used_total)
    );

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during bitmap clear");

    a_found_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_found_frame == '0))
        else $error("found frame not zero on error status");

    a_load_then_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> w_cmd.start)
        else $error("accepted word not evaluated");

    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_out_valid || !i_out_stall))
        else $error("result overwrites a stalled word");

endmodule

`default_nettype wire
